// ----- rtl/core/dbba_pkg.sv -----
package dbba_pkg;

  // Default geometry of the disk.
  localparam int NumTracksDef = 35;
  localparam int DirTrackDef  = 18;

  // Field and storage widths.
  localparam int TrackW = 6;
  localparam int SecW   = 5;
  localparam int MapW   = 21;
  localparam int CntW   = 5;
  localparam int TotalW = 10;

  // Command codes; the three remaining codes are unused and do nothing.
  typedef enum logic [2:0] {
    CMD_TEST   = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_NEAR   = 3'd3,
    CMD_FORMAT = 3'd4
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GIVEN_CHK,
    ST_SRCH_ADDR,
    ST_SRCH_CHK
  } state_e;

  // Command word.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [TrackW-1:0] track;
    logic [SecW-1:0]   sector;
  } in_t;

  // Result word.
  typedef struct packed {
    logic              ok;
    logic [TrackW-1:0] got_track;
    logic [SecW-1:0]   got_sector;
    logic [TotalW-1:0] total_free;
  } out_t;

  // One entry of the availability map: free count and sector bitmap.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [MapW-1:0] map;
  } entry_t;

  // Status returned by the sector unit to the sequencer.
  typedef struct packed {
    logic            sec_ok;
    logic            bit_free;
    logic            found;
    logic [SecW-1:0] fsec;
    entry_t          take_e;
    entry_t          give_e;
  } unit_res_t;

  // Sectors per track for each zone; zero outside the zoned range.
  function automatic logic [SecW-1:0] zone_sectors(input logic [TrackW-1:0] t);
    logic [SecW-1:0] spt;
    spt = '0;
    if (t >= TrackW'(1) && t <= TrackW'(17)) begin
      spt = SecW'(21);
    end else if (t >= TrackW'(18) && t <= TrackW'(24)) begin
      spt = SecW'(19);
    end else if (t >= TrackW'(25) && t <= TrackW'(30)) begin
      spt = SecW'(18);
    end else if (t >= TrackW'(31) && t <= TrackW'(35)) begin
      spt = SecW'(17);
    end
    return spt;
  endfunction

  // Freshly formatted entry of one track; the directory track keeps sectors 0 and 1.
  function automatic entry_t reset_entry(input logic [TrackW-1:0] t,
                                         input logic [TrackW-1:0] dir);
    logic [31:0]     m;
    logic [SecW-1:0] spt;
    entry_t          e;
    spt   = zone_sectors(t);
    m     = (32'd1 << spt) - 32'd1;
    e.map = m[MapW-1:0];
    e.cnt = CntW'(spt);
    if (t == dir) begin
      e.map = e.map & ~MapW'(3);
      e.cnt = CntW'(spt) - CntW'(2);
    end
    return e;
  endfunction

  // Free total of a formatted disk; a directory track of zero gives the maximum.
  function automatic int total_reset(input int num, input int dir);
    int sum;
    sum = 0;
    for (int t = 1; t <= num; t++) begin
      sum = sum + int'(zone_sectors(TrackW'(t)));
      if (t == dir) begin
        sum = sum - 2;
      end
    end
    return sum;
  endfunction

endpackage

// ----- rtl/core/dbba_mem.sv -----
module dbba_mem #(
  parameter int NUM_TRACKS      = dbba_pkg::NumTracksDef,
  parameter int DIRECTORY_TRACK = dbba_pkg::DirTrackDef,
  localparam int AW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  dbba_pkg::entry_t         wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output dbba_pkg::entry_t         rdata_o
);

  localparam logic [dbba_pkg::TrackW-1:0] DirT = dbba_pkg::TrackW'(DIRECTORY_TRACK);

  dbba_pkg::entry_t                mem_q [NUM_TRACKS];
  dbba_pkg::entry_t                raw_q;
  logic [NUM_TRACKS-1:0]           valid_q;
  logic                            rd_vld_q;
  logic [dbba_pkg::TrackW-1:0]     rd_trk_q;

  // Map array with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    raw_q    <= mem_q[raddr_i];
    rd_vld_q <= valid_q[raddr_i];
    rd_trk_q <= dbba_pkg::TrackW'(raddr_i) + dbba_pkg::TrackW'(1);
  end

  // One valid bit per track; reset and format clear them all at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // An entry never written since the last format reads as a formatted track.
  assign rdata_o = rd_vld_q ? raw_q : dbba_pkg::reset_entry(rd_trk_q, DirT);

endmodule

// ----- rtl/core/dbba_unit.sv -----
module dbba_unit (
  input  dbba_pkg::entry_t                entry_i,
  input  logic [dbba_pkg::TrackW-1:0]     track_i,
  input  logic [dbba_pkg::SecW-1:0]       sector_i,
  input  logic                            find_i,
  output dbba_pkg::unit_res_t             res_o
);

  logic [dbba_pkg::SecW-1:0] spt;
  logic [31:0]               map_ext;
  logic [31:0]               mask;
  logic [dbba_pkg::SecW-1:0] fsec;
  logic                      found;
  logic [dbba_pkg::SecW-1:0] target;

  // Bounds check and bit test of the given sector.
  assign spt     = dbba_pkg::zone_sectors(track_i);
  assign map_ext = 32'(entry_i.map);

  // Lowest free sector of the track.
  always_comb begin
    fsec  = '0;
    found = 1'b0;
    for (int i = dbba_pkg::MapW - 1; i >= 0; i--) begin
      if (entry_i.map[i]) begin
        fsec  = dbba_pkg::SecW'(i);
        found = 1'b1;
      end
    end
  end

  // Updated entries for taking or giving back the target sector.
  assign target = find_i ? fsec : sector_i;
  assign mask   = 32'd1 << target;

  always_comb begin
    res_o            = '0;
    res_o.sec_ok     = sector_i < spt;
    res_o.bit_free   = (sector_i < spt) && map_ext[sector_i];
    res_o.found      = found;
    res_o.fsec       = fsec;
    res_o.take_e.map = entry_i.map & ~mask[dbba_pkg::MapW-1:0];
    res_o.take_e.cnt = entry_i.cnt - dbba_pkg::CntW'(1);
    res_o.give_e.map = entry_i.map | mask[dbba_pkg::MapW-1:0];
    res_o.give_e.cnt = entry_i.cnt + dbba_pkg::CntW'(1);
  end

endmodule

// ----- rtl/core/disk_block_bitmap_allocator.sv -----
// Channel   Ports                       Direction  Handshake
// command   in_i (cmd, track, sector)   in         start_i high while busy_o low
// result    res_o (ok, got_track, ...)  out        done_o high for one cycle
//
// Test, allocate and free of a given sector go through the map read and ST_GIVEN_CHK;
// a bad track, format and unused codes finish in the accept cycle.
// The nearest-track search handles a skipped candidate in ST_SRCH_ADDR alone
// and reads a track in ST_SRCH_ADDR (map read), then in ST_SRCH_CHK (shared
// sector unit). Every result shows on done_o the cycle after the command
// finishes. Reset leaves the disk formatted, with no clearing pass.
// The result side cannot stall; a new word is taken while a result is shown.
module disk_block_bitmap_allocator #(
  parameter int NUM_TRACKS      = dbba_pkg::NumTracksDef,
  parameter int DIRECTORY_TRACK = dbba_pkg::DirTrackDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dbba_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           done_o,
  output dbba_pkg::out_t res_o
);

  localparam int AW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int TW = dbba_pkg::TrackW;
  localparam logic [TW-1:0] NumT6 = TW'(NUM_TRACKS);
  localparam logic [TW:0]   NumT7 = (TW + 1)'(NUM_TRACKS);
  localparam logic [TW-1:0] DirT  = TW'(DIRECTORY_TRACK);
  localparam logic [TW:0]   DirT7 = (TW + 1)'(DIRECTORY_TRACK);
  localparam logic [dbba_pkg::TotalW-1:0] TotalReset =
    dbba_pkg::TotalW'(dbba_pkg::total_reset(NUM_TRACKS, DIRECTORY_TRACK));
  localparam logic [dbba_pkg::TotalW-1:0] MaxTotal =
    dbba_pkg::TotalW'(dbba_pkg::total_reset(NUM_TRACKS, 0));

  dbba_pkg::state_e                state_q, state_d;
  logic [dbba_pkg::TotalW-1:0]     total_q, total_d;
  logic                            done_q, done_d;
  dbba_pkg::out_t                  res_q, res_d;
  logic [2:0]                      cmd_q, cmd_d;
  logic [TW-1:0]                   trk_q, trk_d;
  logic [dbba_pkg::SecW-1:0]       sec_q, sec_d;
  logic [TW-1:0]                   hint_q, hint_d;
  logic [TW-1:0]                   d_q, d_d;
  logic                            k_q, k_d;

  logic                            mem_clear;
  logic                            mem_we;
  logic [AW-1:0]                   mem_raddr;
  logic [AW-1:0]                   mem_waddr;
  dbba_pkg::entry_t                mem_wdata;
  dbba_pkg::entry_t                mem_rdata;
  logic                            unit_find;
  dbba_pkg::unit_res_t             ures;

  logic [TW-1:0]                   in_trk_m1;
  logic [TW-1:0]                   trk_m1;
  logic                            in_trk_ok;
  logic [TW:0]                     cand;
  logic [TW:0]                     cand_m1;
  logic                            cand_ok;
  logic                            nxt_k;
  logic [TW-1:0]                   nxt_d;

  // Availability map storage.
  dbba_mem #(
    .NUM_TRACKS      (NUM_TRACKS),
    .DIRECTORY_TRACK (DIRECTORY_TRACK)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mem_clear),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared sector unit: bit test, lowest free sector and entry update.
  dbba_unit u_unit (
    .entry_i  (mem_rdata),
    .track_i  (trk_q),
    .sector_i (sec_q),
    .find_i   (unit_find),
    .res_o    (ures)
  );

  // Track checks and map addresses.
  assign in_trk_m1 = in_i.track - TW'(1);
  assign trk_m1    = trk_q - TW'(1);
  assign mem_waddr = trk_m1[AW-1:0];
  assign in_trk_ok = (in_i.track != '0) && (in_i.track <= NumT6);

  // Search candidate: hint plus distance first, then hint minus distance.
  assign cand    = k_q ? ({1'b0, hint_q} - {1'b0, d_q}) : ({1'b0, hint_q} + {1'b0, d_q});
  assign cand_m1 = cand - (TW + 1)'(1);
  assign cand_ok = !(k_q && (d_q > hint_q)) && (cand != '0) && (cand <= NumT7) &&
                   (cand != DirT7);

  // Next candidate; distance zero is tried only once.
  assign nxt_k = !k_q && (d_q != '0);
  assign nxt_d = nxt_k ? d_q : d_q + TW'(1);

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbba_pkg::ST_IDLE;
      total_q <= TotalReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cmd_q  <= cmd_d;
    trk_q  <= trk_d;
    sec_q  <= sec_d;
    hint_q <= hint_d;
    d_q    <= d_d;
    k_q    <= k_d;
  end

  // Next state, map control and result.
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    done_d    = 1'b0;
    res_d     = '0;
    cmd_d     = cmd_q;
    trk_d     = trk_q;
    sec_d     = sec_q;
    hint_d    = hint_q;
    d_d       = d_q;
    k_d       = k_q;
    mem_clear = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = ures.take_e;
    mem_raddr = trk_m1[AW-1:0];
    unit_find = 1'b0;

    case (state_q)
      dbba_pkg::ST_IDLE: begin
        mem_raddr = in_trk_m1[AW-1:0];
        if (start_i) begin
          cmd_d  = in_i.cmd;
          trk_d  = in_i.track;
          sec_d  = in_i.sector;
          hint_d = (in_i.track == '0) ? DirT : in_i.track;
          d_d    = '0;
          k_d    = 1'b0;
          case (in_i.cmd)
            dbba_pkg::CMD_TEST, dbba_pkg::CMD_ALLOC, dbba_pkg::CMD_FREE: begin
              if (in_trk_ok) begin
                state_d = dbba_pkg::ST_GIVEN_CHK;
              end else begin
                done_d = 1'b1;
              end
            end
            dbba_pkg::CMD_NEAR: begin
              state_d = dbba_pkg::ST_SRCH_ADDR;
            end
            dbba_pkg::CMD_FORMAT: begin
              mem_clear = 1'b1;
              total_d   = TotalReset;
              res_d.ok  = 1'b1;
              done_d    = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Map word of the given track is in; test, take or give back the sector.
      dbba_pkg::ST_GIVEN_CHK: begin
        done_d  = 1'b1;
        state_d = dbba_pkg::ST_IDLE;
        case (cmd_q)
          dbba_pkg::CMD_TEST: begin
            res_d.ok = ures.bit_free;
          end
          dbba_pkg::CMD_ALLOC: begin
            if (ures.bit_free) begin
              mem_we   = 1'b1;
              total_d  = total_q - dbba_pkg::TotalW'(1);
              res_d.ok = 1'b1;
            end
          end
          dbba_pkg::CMD_FREE: begin
            if (ures.sec_ok && !ures.bit_free) begin
              mem_we    = 1'b1;
              mem_wdata = ures.give_e;
              total_d   = total_q + dbba_pkg::TotalW'(1);
              res_d.ok  = 1'b1;
            end
          end
          default: begin
            res_d.ok = 1'b0;
          end
        endcase
      end

      // Issue the next candidate's map read, or end the search at distance NUM_TRACKS.
      dbba_pkg::ST_SRCH_ADDR: begin
        mem_raddr = cand_m1[AW-1:0];
        if (d_q == NumT6) begin
          done_d  = 1'b1;
          state_d = dbba_pkg::ST_IDLE;
        end else if (cand_ok) begin
          trk_d   = cand[TW-1:0];
          state_d = dbba_pkg::ST_SRCH_CHK;
        end else begin
          k_d = nxt_k;
          d_d = nxt_d;
        end
      end

      // Take the lowest free sector of the candidate, or move on.
      dbba_pkg::ST_SRCH_CHK: begin
        unit_find = 1'b1;
        if (ures.found) begin
          mem_we           = 1'b1;
          total_d          = total_q - dbba_pkg::TotalW'(1);
          res_d.ok         = 1'b1;
          res_d.got_track  = trk_q;
          res_d.got_sector = ures.fsec;
          done_d           = 1'b1;
          state_d          = dbba_pkg::ST_IDLE;
        end else begin
          k_d     = nxt_k;
          d_d     = nxt_d;
          state_d = dbba_pkg::ST_SRCH_ADDR;
        end
      end

      default: begin
        state_d = dbba_pkg::ST_IDLE;
      end
    endcase

    res_d.total_free = total_d;
  end

  assign busy_o = (state_q != dbba_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // A search command always keeps the block busy in the next cycle.
  a_near_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (in_i.cmd == dbba_pkg::CMD_NEAR) |=> busy_o)
    else $error("search command did not hold the block busy");

  // An allocated track lies on the disk and is never the directory track.
  a_got_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.got_track != '0) |->
      res_o.ok && (res_o.got_track <= NumT6) && (res_o.got_track != DirT))
    else $error("search returned an illegal track");

  // A failed command reports no track and no sector.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.ok |-> (res_o.got_track == '0) && (res_o.got_sector == '0))
    else $error("failed command reported a location");

  // The free total never exceeds the sector count of the disk.
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxTotal)
    else $error("free total above disk capacity");

  // Format answers at once with the formatted free total.
  a_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (in_i.cmd == dbba_pkg::CMD_FORMAT) |=>
      done_o && res_o.ok && (res_o.total_free == TotalReset))
    else $error("format result wrong");

endmodule

// ----- dv/tb_disk_block_bitmap_allocator.sv -----
module tb_disk_block_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTracks = dbba_pkg::NumTracksDef;
  localparam int DirTrack  = dbba_pkg::DirTrackDef;
  localparam int TrackW    = dbba_pkg::TrackW;
  localparam int SecW      = dbba_pkg::SecW;
  localparam int MapW      = dbba_pkg::MapW;
  localparam int CntW      = dbba_pkg::CntW;
  localparam int TotalW    = dbba_pkg::TotalW;
  // Codes 5 to 7 are spare and must leave the map alone.
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  // Longest run of cycles with no word taken and no result shown.
  localparam int StallLimit = 2000;
  localparam int RandomWords = 435;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  dbba_pkg::in_t  in_i;
  logic           busy_o;
  logic           done_o;
  dbba_pkg::out_t res_o;

  disk_block_bitmap_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #10ns clk_i = ~clk_i;

  // Mirror of the availability map: bitmap, free count per track, total.
  logic [MapW-1:0]   bam_map [1:NumTracks];
  logic [CntW-1:0]   bam_cnt [1:NumTracks];
  logic [TotalW-1:0] bam_total;

  dbba_pkg::out_t bam_reply_q[$];
  dbba_pkg::out_t bam_want;
  int             mismatches = 0;
  int             stall_cycles = 0;
  bit             gaps_on = 1'b1;

  // Sectors on a track of the zoned layout; zero for a track off the disk.
  function automatic int sectors_on(int t);
    if (t < 1 || t > NumTracks) return 0;
    if (t <= 17) return 21;
    if (t <= 24) return 19;
    if (t <= 30) return 18;
    return 17;
  endfunction

  // A formatted disk: all sectors free but the first two of the directory track.
  function automatic void format_bam();
    int spt;
    bam_total = '0;
    for (int t = 1; t <= NumTracks; t++) begin
      spt        = sectors_on(t);
      bam_map[t] = MapW'((32'd1 << spt) - 32'd1);
      bam_cnt[t] = CntW'(spt);
      if (t == DirTrack) begin
        bam_map[t] = bam_map[t] & ~MapW'(3);
        bam_cnt[t] = bam_cnt[t] - CntW'(2);
      end
      bam_total = bam_total + TotalW'(bam_cnt[t]);
    end
  endfunction

  function automatic void take_sector(int t, int s);
    bam_map[t][s] = 1'b0;
    bam_cnt[t]    = bam_cnt[t] - CntW'(1);
    bam_total     = bam_total - TotalW'(1);
  endfunction

  // Applies one command word to the mirror and returns the reply it must give.
  function automatic dbba_pkg::out_t predict_bam_reply(dbba_pkg::in_t w);
    dbba_pkg::out_t r;
    int             spt;
    int             hint;
    int             t;
    bit             valid;
    r     = '0;
    spt   = sectors_on(int'(w.track));
    valid = (spt != 0) && (int'(w.sector) < spt);
    case (w.cmd)
      dbba_pkg::CMD_TEST: begin
        if (valid) r.ok = bam_map[w.track][w.sector];
      end
      dbba_pkg::CMD_ALLOC: begin
        if (valid && bam_map[w.track][w.sector]) begin
          take_sector(int'(w.track), int'(w.sector));
          r.ok = 1'b1;
        end
      end
      dbba_pkg::CMD_FREE: begin
        if (valid && !bam_map[w.track][w.sector]) begin
          bam_map[w.track][w.sector] = 1'b1;
          bam_cnt[w.track] = bam_cnt[w.track] + CntW'(1);
          bam_total = bam_total + TotalW'(1);
          r.ok = 1'b1;
        end
      end
      dbba_pkg::CMD_NEAR: begin
        // Hint first, then hint+d before hint-d; the directory track is skipped.
        hint = (w.track == '0) ? DirTrack : int'(w.track);
        for (int d = 0; d < NumTracks; d++) begin
          for (int k = 0; k < 2; k++) begin
            t = (k == 0) ? hint + d : hint - d;
            if (!r.ok && t >= 1 && t <= NumTracks && t != DirTrack) begin
              for (int s = 0; s < sectors_on(t); s++) begin
                if (!r.ok && bam_map[t][s]) begin
                  take_sector(t, s);
                  r.ok         = 1'b1;
                  r.got_track  = TrackW'(t);
                  r.got_sector = SecW'(s);
                end
              end
            end
          end
        end
      end
      dbba_pkg::CMD_FORMAT: begin
        format_bam();
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.total_free = bam_total;
    return r;
  endfunction

  // Sends one command word, with random gaps before it when gaps are enabled.
  task automatic issue_word(logic [2:0] cmd, int track, int sector);
    dbba_pkg::in_t  w;
    dbba_pkg::out_t reply;
    w.cmd    = cmd;
    w.track  = TrackW'(track);
    w.sector = SecW'(sector);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      in_i    <= dbba_pkg::in_t'($urandom);
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    reply = predict_bam_reply(w);
    bam_reply_q.insert(bam_reply_q.size(), reply);
  endtask

  // Field extremes, every command and the rejection cases on a fresh disk.
  task automatic test_directed();
    issue_word(dbba_pkg::CMD_TEST, 1, 0);
    issue_word(dbba_pkg::CMD_TEST, 0, 0);
    issue_word(dbba_pkg::CMD_TEST, NumTracks + 1, 0);
    issue_word(dbba_pkg::CMD_TEST, 63, 31);
    issue_word(dbba_pkg::CMD_TEST, 1, 20);
    issue_word(dbba_pkg::CMD_TEST, 1, 21);
    issue_word(dbba_pkg::CMD_TEST, DirTrack, 0);
    issue_word(dbba_pkg::CMD_TEST, DirTrack, 19);
    issue_word(dbba_pkg::CMD_TEST, NumTracks, 17);
    issue_word(dbba_pkg::CMD_TEST, NumTracks, 16);
    issue_word(dbba_pkg::CMD_ALLOC, 1, 0);
    issue_word(dbba_pkg::CMD_ALLOC, 1, 0);
    issue_word(dbba_pkg::CMD_FREE, 1, 0);
    issue_word(dbba_pkg::CMD_FREE, 1, 0);
    issue_word(dbba_pkg::CMD_ALLOC, DirTrack, 0);
    issue_word(dbba_pkg::CMD_FREE, DirTrack, 0);
    issue_word(dbba_pkg::CMD_ALLOC, DirTrack, 0);
    issue_word(dbba_pkg::CMD_NEAR, 0, 31);
    issue_word(dbba_pkg::CMD_NEAR, DirTrack, 0);
    issue_word(dbba_pkg::CMD_NEAR, 63, 0);
    issue_word(dbba_pkg::CMD_NEAR, 1, 0);
    issue_word(CmdSpareLo, 1, 1);
    issue_word(CmdSpareLo + 3'd1, 2, 2);
    issue_word(CmdSpareHi, 63, 31);
    issue_word(dbba_pkg::CMD_FORMAT, 0, 0);
  endtask

  // Fills the disk by searches, then drains the directory track and probes the
  // empty disk, including a far hint that cannot reach the only free sector.
  task automatic test_fill_disk();
    while (bam_total != TotalW'(bam_cnt[DirTrack])) begin
      issue_word(dbba_pkg::CMD_NEAR, $urandom_range(NumTracks), $urandom_range(31));
    end
    issue_word(dbba_pkg::CMD_NEAR, 0, 0);
    issue_word(dbba_pkg::CMD_NEAR, NumTracks, 0);
    issue_word(dbba_pkg::CMD_NEAR, 63, 0);
    for (int s = 0; s < sectors_on(DirTrack); s++) begin
      issue_word(dbba_pkg::CMD_ALLOC, DirTrack, s);
    end
    issue_word(dbba_pkg::CMD_TEST, 1, 20);
    issue_word(dbba_pkg::CMD_FREE, 1, 20);
    issue_word(dbba_pkg::CMD_NEAR, 63, 0);
    issue_word(dbba_pkg::CMD_NEAR, 1, 0);
    issue_word(dbba_pkg::CMD_FORMAT, 0, 0);
  endtask

  // Mostly well-formed traffic on valid sectors, with some noise and formats.
  task automatic test_random_traffic();
    int pick;
    int t;
    for (int n = 0; n < RandomWords; n++) begin
      gaps_on = !(n >= 100 && n < 350);
      pick    = $urandom_range(99);
      t       = $urandom_range(1, NumTracks);
      if (pick < 12) begin
        issue_word(dbba_pkg::CMD_TEST, t, $urandom_range(sectors_on(t) - 1));
      end else if (pick < 40) begin
        issue_word(dbba_pkg::CMD_ALLOC, t, $urandom_range(sectors_on(t) - 1));
      end else if (pick < 55) begin
        // Low sectors are the ones searches hand out, so frees often succeed.
        issue_word(dbba_pkg::CMD_FREE, t,
                   ($urandom_range(1) != 0) ? $urandom_range(4)
                                            : $urandom_range(sectors_on(t) - 1));
      end else if (pick < 88) begin
        issue_word(dbba_pkg::CMD_NEAR,
                   ($urandom_range(9) == 0) ? $urandom_range(63)
                                            : $urandom_range(NumTracks),
                   $urandom_range(31));
      end else if (pick < 89) begin
        issue_word(dbba_pkg::CMD_FORMAT, $urandom_range(63), $urandom_range(31));
      end else begin
        issue_word(3'($urandom_range(7)), $urandom_range(63), $urandom_range(31));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Each result word is checked against the oldest reply still owed.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (bam_reply_q.size() == 0) begin
        $error("result word with no command outstanding");
        mismatches++;
      end else begin
        bam_want = bam_reply_q.pop_front();
        if (res_o.ok !== bam_want.ok) begin
          $error("ok: expected %0d, got %0d", bam_want.ok, res_o.ok);
          mismatches++;
        end
        if (res_o.got_track !== bam_want.got_track) begin
          $error("got_track: expected %0d, got %0d", bam_want.got_track, res_o.got_track);
          mismatches++;
        end
        if (res_o.got_sector !== bam_want.got_sector) begin
          $error("got_sector: expected %0d, got %0d", bam_want.got_sector, res_o.got_sector);
          mismatches++;
        end
        if (res_o.total_free !== bam_want.total_free) begin
          $error("total_free: expected %0d, got %0d", bam_want.total_free, res_o.total_free);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_disk_block_bitmap_allocator: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    format_bam();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_fill_disk();
    test_random_traffic();

    @(negedge clk_i);
    start_i <= 1'b0;
    while (bam_reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_disk_block_bitmap_allocator: clean");
    end else begin
      $display("tb_disk_block_bitmap_allocator: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dbba_pkg.sv
rtl/core/dbba_mem.sv
rtl/core/dbba_unit.sv
rtl/core/disk_block_bitmap_allocator.sv
dv/tb_disk_block_bitmap_allocator.sv
